// File: src/acf_pkg.sv
// Shared types, widths and constants of the continued-fraction arctangent core.
package acf_pkg;

	// Fraction bits of the internal unsigned fixed-point format.
	localparam int FRAC = 30;
	// Number of continued-fraction terms.
	localparam int TERMS = 24;
	localparam int TERM_W = 6;

	// Quotient bits per division; every quotient in the core is below 2^QW.
	localparam int QW = 35;
	// Remainder and divisor widths; divisors stay below 2^DW.
	localparam int DW = 36;
	localparam int RW = DW + 1;
	localparam int PW = RW + QW;
	// Low dividend bits that go into the quotient half at setup; the rest fill the remainder half.
	localparam int SPLIT = QW - FRAC;
	// Width of a term numerator z*z*sq.
	localparam int NW = 40;
	// Width of the folded ratio and of its square.
	localparam int MW = FRAC + 1;

	// Square root of a value of at most 2^62: one result bit per step.
	localparam int VW = 63;
	localparam int SQ_STEPS = 32;
	localparam int STEP_W = 5;

	localparam logic [63:0] PI_Q61 = 64'h6487ED5110B4611A;
	localparam logic [31:0] PI_QF = 32'((PI_Q61 + (64'd1 << (60 - FRAC))) >> (61 - FRAC));
	localparam logic [31:0] HALF_PI_QF =
		32'(((PI_Q61 >> 1) + (64'd1 << (60 - FRAC))) >> (61 - FRAC));
	localparam logic [31:0] HALF_PI_Q29 = 32'((33'(HALF_PI_QF) + 33'd1) >> 1);
	localparam logic [31:0] ANGLE_MAX = 32'd1686629713;
	localparam logic [DW-1:0] ONE_QF = DW'(1) << FRAC;
	localparam logic [31:0] UNIT_Q16 = 32'd65536;

	typedef enum logic [1:0] {
		FUNC_ATAN2 = 2'd0,
		FUNC_ATAN  = 2'd1,
		FUNC_ASIN  = 2'd2,
		FUNC_NONE  = 2'd3
	} acf_func_t;

	typedef struct packed {
		logic [1:0]         func;
		logic signed [31:0] y_value;
		logic signed [31:0] x_value;
	} acf_req_t;

	typedef struct packed {
		logic signed [31:0] angle;
		logic               domain_error;
	} acf_rsp_t;

	// Operands after sign split and mode mapping.
	typedef struct packed {
		acf_func_t   func;
		logic [31:0] ay;
		logic [31:0] ax;
		logic        yneg;
		logic        xneg;
		logic        dom;
	} acf_front_t;

	typedef struct packed {
		logic           valid;
		logic [VW-1:0]  v;
		logic [VW-1:0]  res;
		acf_front_t     op;
	} acf_root_t;

	// What the quadrant rebuild needs once the arctangent is done.
	typedef struct packed {
		logic        special;
		logic [31:0] spec_angle;
		logic        swap;
		logic        xneg;
		logic        yneg;
		logic        dom;
	} acf_side_t;

	// pr holds the partial remainder above the dividend and quotient bits.
	typedef struct packed {
		logic          valid;
		logic [PW-1:0] pr;
		logic [DW-1:0] den;
		logic [MW-1:0] sq;
		logic [MW-1:0] r;
		acf_side_t     side;
	} acf_div_t;

endpackage

// File: src/acf_sqrt_cell.sv
// One step of the integer square root: settles one result bit per cycle while ce is high.
module acf_sqrt_cell import acf_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              ce,
	input  logic [STEP_W-1:0] step,
	input  acf_root_t         d,
	output acf_root_t         q
);

	localparam logic [5:0] TOP = 6'(VW - 1);

	logic [VW-1:0] bit_w;
	logic [VW:0]   trial;
	acf_root_t     nxt;

	always_comb begin
		bit_w = VW'(1) << (TOP - {step, 1'b0});
		trial = {1'b0, d.res} + {1'b0, bit_w};
		nxt = d;
		if ({1'b0, d.v} >= trial) begin
			nxt.v = d.v - trial[VW-1:0];
			nxt.res = (d.res >> 1) + bit_w;
		end else begin
			nxt.res = d.res >> 1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			q <= '0;
		end else if (ce) begin
			q <= nxt;
		end
	end

endmodule

// File: src/acf_div_cell.sv
// One restoring division step: shifts in a dividend bit and decides one quotient bit.
module acf_div_cell import acf_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     ce,
	input  acf_div_t d,
	output acf_div_t q
);

	logic [PW-1:0] shifted;
	logic [RW-1:0] cand;
	acf_div_t      nxt;

	always_comb begin
		shifted = d.pr << 1;
		cand = shifted[PW-1:QW];
		nxt = d;
		if (cand >= {1'b0, d.den}) begin
			shifted[PW-1:QW] = cand - {1'b0, d.den};
			shifted[0] = 1'b1;
		end
		nxt.pr = shifted;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			q <= '0;
		end else if (ce) begin
			q <= nxt;
		end
	end

endmodule

// File: src/acf_setup_cell.sv
// Loads the divider for one continued-fraction term, or for the closing 1+conv division.
module acf_setup_cell import acf_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              ce,
	input  logic [TERM_W-1:0] term,
	input  acf_div_t          d,
	output acf_div_t          q
);

	logic [QW-1:0]       conv;
	logic [2*TERM_W-1:0] zz;
	logic [NW-1:0]       num;
	logic [DW-1:0]       den;
	acf_div_t            nxt;

	always_comb begin
		conv = d.pr[QW-1:0];
		zz = {{TERM_W{1'b0}}, term} * {{TERM_W{1'b0}}, term};
		// A term index of zero marks the final division r / (1 + conv).
		if (term == '0) begin
			num = NW'(d.r);
			den = ONE_QF + DW'(conv);
		end else begin
			num = NW'(zz * d.sq);
			den = (DW'({term, 1'b1}) << FRAC) + DW'(conv);
		end
		nxt = d;
		nxt.den = den;
		nxt.pr = {RW'(num >> SPLIT), QW'(num[SPLIT-1:0]) << FRAC};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			q <= '0;
		end else if (ce) begin
			q <= nxt;
		end
	end

endmodule

// File: src/atan2_continued_fraction_core.sv
// Top level of the pipelined atan2 / atan / asin core.
// Fully pipelined arctangent core: one request beat per cycle while req_ready is high, and
// every request gives one response beat. The pipeline is built from a chain of one-bit
// cells: 32 square-root steps for asin, a 35-step divider for
// the folded ratio, then 24 continued-fraction terms and a closing division, each a setup
// cell and 35 divider cells. Modes: 0 atan2(y,x), 1 atan(y), 2 asin(y) with domain_error set
// when |y| > 1, 3 returns zero. Operands are signed Q16.16; the angle is signed Q2.29. A
// two-entry output buffer lets the pipeline keep moving while one response waits; a stall
// longer than that holds the whole pipeline and drops req_ready.
module atan2_continued_fraction_core import acf_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     req_valid,
	output logic     req_ready,
	input  acf_req_t req,
	output logic     rsp_valid,
	input  logic     rsp_ready,
	output acf_rsp_t rsp
);

	typedef struct packed {
		logic       valid;
		acf_front_t op;
	} acf_front_stage_t;

	typedef struct packed {
		logic        valid;
		logic [31:0] t;
		acf_side_t   side;
	} acf_post_t;

	logic ce;

	acf_front_stage_t front_s1;
	acf_root_t        root_c [SQ_STEPS+1];
	acf_div_t         ratio_c [QW+1];
	acf_div_t         sq_s;
	acf_div_t         term_c [TERMS+1][QW+1];
	acf_post_t        post_s1;

	acf_rsp_t out_q, skid_q;
	logic     out_valid_q, skid_valid_q;

	assign ce = !skid_valid_q;
	assign req_ready = ce;

	// Sign split and mode mapping.
	acf_front_stage_t front_d;
	logic [31:0]      ymag, xmag;

	always_comb begin
		ymag = req.y_value[31] ? 32'(32'd0 - req.y_value) : 32'(req.y_value);
		xmag = req.x_value[31] ? 32'(32'd0 - req.x_value) : 32'(req.x_value);
		front_d = '0;
		front_d.valid = req_valid;
		front_d.op.func = acf_func_t'(req.func);
		front_d.op.yneg = req.y_value[31];
		front_d.op.ay = ymag;
		case (acf_func_t'(req.func))
			FUNC_ATAN2: begin
				front_d.op.ax = xmag;
				front_d.op.xneg = req.x_value[31];
			end
			FUNC_ATAN: begin
				front_d.op.ax = UNIT_Q16;
			end
			FUNC_ASIN: begin
				if (ymag > UNIT_Q16) begin
					front_d.op.ay = UNIT_Q16;
					front_d.op.dom = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_s1 <= '0;
		end else if (ce) begin
			front_s1 <= front_d;
		end
	end

	// Radicand (1 - y^2) scaled to Q62 for the asin cosine leg.
	acf_root_t   root_d;
	logic [33:0] ysq;

	always_comb begin
		ysq = 34'(front_s1.op.ay[16:0]) * 34'(front_s1.op.ay[16:0]);
		root_d.valid = front_s1.valid;
		root_d.op = front_s1.op;
		root_d.res = '0;
		root_d.v = VW'(33'(33'd1 << 32) - 33'(ysq)) << FRAC;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			root_c[0] <= '0;
		end else if (ce) begin
			root_c[0] <= root_d;
		end
	end

	for (genvar k = 0; k < SQ_STEPS; k++) begin : g_sqrt
		acf_sqrt_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.ce     (ce),
			.step   (STEP_W'(k)),
			.d      (root_c[k]),
			.q      (root_c[k+1])
		);
	end

	// Final operands, special cases and the folded ratio division.
	acf_div_t    prep_d;
	acf_front_t  pop;
	logic [31:0] ayf, axf, num, den;

	always_comb begin
		pop = root_c[SQ_STEPS].op;
		if (pop.func == FUNC_ASIN) begin
			ayf = pop.ay << 15;
			axf = root_c[SQ_STEPS].res[31:0];
		end else begin
			ayf = pop.ay;
			axf = pop.ax;
		end
		prep_d = '0;
		prep_d.valid = root_c[SQ_STEPS].valid;
		prep_d.side.dom = pop.dom;
		prep_d.side.xneg = pop.xneg;
		prep_d.side.yneg = pop.yneg && (ayf != '0);
		prep_d.side.swap = ayf > axf;
		if (pop.func == FUNC_NONE) begin
			prep_d.side.special = 1'b1;
		end else if (ayf == '0 && axf == '0) begin
			prep_d.side.special = 1'b1;
		end else if (axf == '0) begin
			prep_d.side.special = 1'b1;
			prep_d.side.spec_angle = pop.yneg ? 32'd0 - HALF_PI_Q29 : HALF_PI_Q29;
		end
		num = prep_d.side.swap ? axf : ayf;
		den = prep_d.side.swap ? ayf : axf;
		prep_d.den = DW'(den);
		prep_d.pr = {RW'(num >> SPLIT), QW'(num[SPLIT-1:0]) << FRAC};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ratio_c[0] <= '0;
		end else if (ce) begin
			ratio_c[0] <= prep_d;
		end
	end

	for (genvar k = 0; k < QW; k++) begin : g_ratio
		acf_div_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.ce     (ce),
			.d      (ratio_c[k]),
			.q      (ratio_c[k+1])
		);
	end

	// Square of the ratio; the cleared pr gives the first term a zero tail.
	acf_div_t          sq_d;
	logic [2*MW-1:0]   rsq;

	always_comb begin
		sq_d = ratio_c[QW];
		sq_d.r = ratio_c[QW].pr[MW-1:0];
		rsq = (2*MW)'(sq_d.r) * (2*MW)'(sq_d.r);
		sq_d.sq = MW'(rsq >> FRAC);
		sq_d.pr = '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sq_s <= '0;
		end else if (ce) begin
			sq_s <= sq_d;
		end
	end

	for (genvar t = 0; t <= TERMS; t++) begin : g_term
		acf_setup_cell u_setup (
			.clk    (clk),
			.arst_n (arst_n),
			.ce     (ce),
			.term   (TERM_W'(TERMS - t)),
			.d      ((t == 0) ? sq_s : term_c[(t == 0) ? 0 : t-1][QW]),
			.q      (term_c[t][0])
		);
		for (genvar k = 0; k < QW; k++) begin : g_step
			acf_div_cell u_cell (
				.clk    (clk),
				.arst_n (arst_n),
				.ce     (ce),
				.d      (term_c[t][k]),
				.q      (term_c[t][k+1])
			);
		end
	end

	// Quadrant rebuild.
	acf_post_t   post_d;
	logic [31:0] t0, ta;

	always_comb begin
		t0 = 32'(term_c[TERMS][QW].pr[MW-1:0]);
		ta = term_c[TERMS][QW].side.swap ? HALF_PI_QF - t0 : t0;
		post_d.valid = term_c[TERMS][QW].valid;
		post_d.side = term_c[TERMS][QW].side;
		post_d.t = term_c[TERMS][QW].side.xneg ? PI_QF - ta : ta;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			post_s1 <= '0;
		end else if (ce) begin
			post_s1 <= post_d;
		end
	end

	// Round to Q2.29, clamp, apply sign.
	acf_rsp_t    beat;
	logic [31:0] mag;

	always_comb begin
		mag = 32'((33'(post_s1.t) + 33'd1) >> 1);
		if (mag > ANGLE_MAX) begin
			mag = ANGLE_MAX;
		end
		beat.domain_error = post_s1.side.dom;
		if (post_s1.side.special) begin
			beat.angle = post_s1.side.spec_angle;
		end else begin
			beat.angle = post_s1.side.yneg ? 32'd0 - mag : mag;
		end
	end

	// Output register with one skid entry behind it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (ce && post_s1.valid) begin
			if (out_valid_q && !rsp_ready) begin
				skid_valid_q <= 1'b1;
			end else begin
				out_valid_q <= 1'b1;
			end
		end else if (rsp_ready) begin
			if (skid_valid_q) begin
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ce && post_s1.valid) begin
			if (out_valid_q && !rsp_ready) begin
				skid_q <= beat;
			end else begin
				out_q <= beat;
			end
		end else if (rsp_ready && skid_valid_q) begin
			out_q <= skid_q;
		end
	end

	assign rsp_valid = out_valid_q;
	assign rsp = out_q;

endmodule

// File: src/acf_checker.sv
// Port-level checks for the arctangent core, bound to its top level.
module acf_checker import acf_pkg::*; (
	input logic     clk,
	input logic     arst_n,
	input logic     req_ready,
	input logic     rsp_valid,
	input logic     rsp_ready,
	input acf_rsp_t rsp
);

	// The skid entry only fills behind a waiting response.
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!rsp_valid |-> req_ready)
		else $error("request side stalled with no response pending");

	// A clamped asin argument always lands on plus or minus pi/2.
	a_domain_angle: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.domain_error |->
			(rsp.angle == HALF_PI_Q29) || (rsp.angle == 32'd0 - HALF_PI_Q29))
		else $error("domain error beat without a right angle");

	a_angle_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> ($signed(rsp.angle) <= $signed(ANGLE_MAX)) &&
			($signed(rsp.angle) >= -$signed(ANGLE_MAX)))
		else $error("angle beyond pi");

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
		else $error("stalled response beat changed");

endmodule

bind atan2_continued_fraction_core acf_checker u_acf_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_ready (req_ready),
	.rsp_valid (rsp_valid),
	.rsp_ready (rsp_ready),
	.rsp       (rsp)
);

// File: tb/acf_result_checker.sv
// Checker for the arctangent core: predicts each response from the accepted requests.
`timescale 1ns / 1ps
module acf_result_checker import acf_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     req_valid,
	input  logic     req_ready,
	input  acf_req_t req,
	input  logic     rsp_valid,
	input  logic     rsp_ready,
	input  acf_rsp_t rsp,
	output int       fail_count,
	output int       pending
);

	acf_rsp_t expected_rsps[$];

	// Truncating fixed-point divide: (num << FRAC) / den.
	function automatic logic [63:0] qdiv(input logic [63:0] num, input logic [63:0] den);
		logic [127:0] n;
		if (den == 0)
			return 64'd0;
		n = {64'd0, num} << FRAC;
		return 64'(n / {64'd0, den});
	endfunction

	function automatic logic [63:0] int_sqrt(input logic [63:0] v);
		logic [63:0] res, b;
		res = 0;
		b = 64'd1 << 62;
		while (b > v)
			b = b >> 2;
		while (b != 0) begin
			if (v >= res + b) begin
				v = v - (res + b);
				res = (res >> 1) + b;
			end else begin
				res = res >> 1;
			end
			b = b >> 2;
		end
		return res;
	endfunction

	// Continued-fraction arctangent of a ratio in [0,1], both in Q1.30.
	function automatic logic [63:0] arctan_unit(input logic [63:0] r);
		logic [63:0] sq, conv, den;
		sq = (r * r) >> FRAC;
		conv = 0;
		for (int z = TERMS; z > 0; z--) begin
			den = (64'(2 * z + 1) << FRAC) + conv;
			conv = qdiv(64'(z * z) * sq, den);
		end
		return qdiv(r, (64'd1 << FRAC) + conv);
	endfunction

	// Rounds Q2.30 to Q2.29, clamps, and applies the sign.
	function automatic logic [31:0] to_angle(input logic [63:0] m, input logic neg);
		m = (m + 64'd1) >> 1;
		if (m > 64'(ANGLE_MAX))
			m = 64'(ANGLE_MAX);
		return neg ? 32'(64'd0 - m) : m[31:0];
	endfunction

	function automatic logic [31:0] quadrant_angle(input logic [63:0] ay, input logic yneg,
			input logic [63:0] ax, input logic xneg);
		logic [63:0] t;
		if (ay == 0 && ax == 0)
			return 32'd0;
		if (ax == 0)
			return to_angle(64'(HALF_PI_QF), yneg);
		if (ay <= ax)
			t = arctan_unit(qdiv(ay, ax));
		else
			t = 64'(HALF_PI_QF) - arctan_unit(qdiv(ax, ay));
		if (xneg)
			t = 64'(PI_QF) - t;
		return to_angle(t, yneg && ay != 0);
	endfunction

	function automatic acf_rsp_t predict_angle(input acf_req_t r);
		acf_rsp_t o;
		logic [63:0] ay, ax, c;
		logic yneg, xneg;
		yneg = r.y_value[31];
		xneg = r.x_value[31];
		ay = yneg ? 64'h1_0000_0000 - {32'd0, r.y_value} : {32'd0, r.y_value};
		ax = xneg ? 64'h1_0000_0000 - {32'd0, r.x_value} : {32'd0, r.x_value};
		o = '0;
		case (acf_func_t'(r.func))
			FUNC_ATAN2: o.angle = quadrant_angle(ay, yneg, ax, xneg);
			FUNC_ATAN:  o.angle = quadrant_angle(ay, yneg, 64'd65536, 1'b0);
			FUNC_ASIN: begin
				if (ay > 64'd65536) begin
					ay = 64'd65536;
					o.domain_error = 1'b1;
				end
				c = int_sqrt(((64'd1 << 32) - ay * ay) << 30);
				o.angle = quadrant_angle(ay << 15, yneg, c, 1'b0);
			end
			default: o = '0;
		endcase
		return o;
	endfunction

	assign pending = expected_rsps.size();

	always @(posedge clk) begin
		acf_rsp_t exp_rsp;
		if (!arst_n) begin
			fail_count = 0;
		end else begin
			if (req_valid && req_ready)
				expected_rsps.push_back(predict_angle(req));
			if (rsp_valid && rsp_ready) begin
				if (expected_rsps.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("unexpected response beat: angle %0d dom %0b",
							rsp.angle, rsp.domain_error);
				end else begin
					exp_rsp = expected_rsps.pop_front();
					if (rsp.angle !== exp_rsp.angle
							|| rsp.domain_error !== exp_rsp.domain_error) begin
						fail_count++;
						if (fail_count <= 10)
							$display("mismatch: angle exp %0d got %0d, dom exp %0b got %0b",
								exp_rsp.angle, rsp.angle, exp_rsp.domain_error,
								rsp.domain_error);
					end
				end
			end
		end
	end

endmodule

// File: tb/atan2_continued_fraction_core_test.sv
// Stimulus and verdict for the continued-fraction arctangent core.
`timescale 1ns / 1ps
module atan2_continued_fraction_core_test;
	import acf_pkg::*;

	logic     clk = 0;
	logic     arst_n = 0;
	logic     req_valid = 0;
	logic     req_ready;
	acf_req_t req = '0;
	logic     rsp_valid;
	logic     rsp_ready = 0;
	acf_rsp_t rsp;
	int       fail_count;
	int       pending;
	bit       no_gaps = 0;
	int       rsp_wait = 0;
	int       rsp_draw;
	logic     rsp_took = 0;

	always #2 clk = ~clk;

	atan2_continued_fraction_core u_top (
		.clk(clk), .arst_n(arst_n), .req_valid(req_valid), .req_ready(req_ready),
		.req(req), .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp)
	);

	acf_result_checker u_checker (
		.clk(clk), .arst_n(arst_n), .req_valid(req_valid), .req_ready(req_ready),
		.req(req), .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp),
		.fail_count(fail_count), .pending(pending)
	);

	// Called at a falling edge; returns at the falling edge after the beat.
	task automatic send(input acf_func_t f, input logic [31:0] y, input logic [31:0] x);
		int gap;
		gap = no_gaps ? 0 : $urandom_range(0, 9);
		if (gap > 0) begin
			req_valid = 0;
			repeat (gap) @(negedge clk);
		end
		req.func = f;
		req.y_value = y;
		req.x_value = x;
		req_valid = 1;
		do @(posedge clk); while (!req_ready);
		@(negedge clk);
	endtask

	function automatic logic [31:0] rand_operand();
		case ($urandom_range(0, 5))
			0: return $urandom();
			1: return 32'($signed($urandom_range(0, 131072)) - 65536);
			2: return 32'($signed($urandom_range(0, 8192)) - 4096);
			3: return 32'd0;
			4: return {$urandom_range(0, 1) ? 16'hFFFF : 16'h0000, 16'($urandom())};
			default: return $urandom() >> $urandom_range(0, 31);
		endcase
	endfunction

	// Response side: random stall before each beat, none during bursts.
	always @(posedge clk)
		rsp_took <= rsp_valid && rsp_ready;

	always @(negedge clk) begin
		rsp_draw = rsp_took ? (no_gaps ? 0 : $urandom_range(0, 9)) : rsp_wait;
		if (rsp_draw > 0) begin
			rsp_ready <= 0;
			rsp_wait <= rsp_draw - 1;
		end else begin
			rsp_ready <= 1;
		end
	end

	initial begin
		#5000000;
		$display("FAIL atan2_continued_fraction_core");
		$finish;
	end

	initial begin
		logic [31:0] y, x;
		acf_func_t f;
		repeat (7) @(negedge clk);
		arst_n = 1;
		@(negedge clk);

		// Directed: special quadrants, extremes, asin domain edges, unused selector.
		send(FUNC_ATAN2, 32'd0, 32'd0);
		send(FUNC_ATAN2, 32'd65536, 32'd0);
		send(FUNC_ATAN2, 32'hFFFF0000, 32'd0);
		send(FUNC_ATAN2, 32'd0, 32'hFFFF0000);
		send(FUNC_ATAN2, 32'd0, 32'd65536);
		send(FUNC_ATAN2, 32'h80000000, 32'h80000000);
		send(FUNC_ATAN2, 32'h7FFFFFFF, 32'h80000000);
		send(FUNC_ATAN2, 32'h80000000, 32'h7FFFFFFF);
		send(FUNC_ATAN2, 32'h7FFFFFFF, 32'h7FFFFFFF);
		send(FUNC_ATAN2, 32'd1, 32'h7FFFFFFF);
		send(FUNC_ATAN2, 32'hFFFFFFFF, 32'hFFFFFFFF);
		send(FUNC_ATAN, 32'd0, 32'hFFFFFFFF);
		send(FUNC_ATAN, 32'h7FFFFFFF, 32'd0);
		send(FUNC_ATAN, 32'h80000000, 32'd0);
		send(FUNC_ATAN, 32'd65536, 32'd0);
		send(FUNC_ASIN, 32'd65536, 32'd0);
		send(FUNC_ASIN, 32'hFFFF0000, 32'd0);
		send(FUNC_ASIN, 32'd65537, 32'd0);
		send(FUNC_ASIN, 32'h80000000, 32'h7FFFFFFF);
		send(FUNC_ASIN, 32'd0, 32'd0);
		send(FUNC_ASIN, 32'd32768, 32'd0);
		send(FUNC_NONE, 32'h7FFFFFFF, 32'h80000000);

		for (int i = 0; i < 1600; i++) begin
			if (i % 200 == 0)
				no_gaps = ($urandom_range(0, 2) == 0);
			if (i == 800) begin
				// Let the pipeline drain completely before resuming.
				req_valid = 0;
				wait (pending == 0);
				@(negedge clk);
			end
			f = acf_func_t'($urandom_range(0, 9) == 0 ? 3 : $urandom_range(0, 2));
			y = rand_operand();
			x = rand_operand();
			if ($urandom_range(0, 15) == 0)
				x = $urandom_range(0, 1) ? y : 32'(-$signed(y));
			send(f, y, x);
		end
		req_valid = 0;
		no_gaps = 0;
		wait (pending == 0);
		repeat (1000) @(posedge clk);
		if (fail_count == 0)
			$display("PASS atan2_continued_fraction_core");
		else
			$display("FAIL atan2_continued_fraction_core");
		$finish;
	end

endmodule
